/* rtl/circumcircle_2d_centre_radius_assert.svh */
// Assertion macros for the circumcircle block.
// Depends on nothing; included by the top level.
`ifndef CIRCUMCIRCLE_2D_CENTRE_RADIUS_ASSERT_SVH
`define CIRCUMCIRCLE_2D_CENTRE_RADIUS_ASSERT_SVH

// Same-cycle implication.
`define CIRC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CIRC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/circ_pkg.sv */
// Shared constants, width functions and types of the circumcircle block.
// Depends on nothing.
package circ_pkg;

  localparam int IN_W           = 12;
  localparam int OUT_W          = 32;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int FIFO_DEPTH     = 4;
  localparam int SQRT_STEPS     = 32;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic int diff_w(input int cw);
    return cw + 1;
  endfunction

  function automatic int prod_w(input int cw);
    return 2 * (cw + 1);
  endfunction

  function automatic int den_w(input int cw);
    return 2 * (cw + 1) + 2;
  endfunction

  function automatic int num_w(input int cw, input int fb);
    return 3 * (cw + 1) + 3 + fb;
  endfunction

  function automatic int item_w(input int cw, input int fb);
    return 3 + den_w(cw) + 2 * num_w(cw, fb) + 2 * cw;
  endfunction

  function automatic int ext_w(input int cw, input int fb);
    int q;
    q = num_w(cw, fb) + 2;
    return (q > 33) ? q : 33;
  endfunction

endpackage

/* rtl/circ_chan_if.sv */
// Request and result channel interfaces of the circumcircle block.
// Depends on circ_pkg.
interface circ_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [circ_pkg::IN_W-1:0]  point_a_x;
  logic signed [circ_pkg::IN_W-1:0]  point_a_y;
  logic signed [circ_pkg::IN_W-1:0]  point_b_x;
  logic signed [circ_pkg::IN_W-1:0]  point_b_y;
  logic signed [circ_pkg::IN_W-1:0]  point_c_x;
  logic signed [circ_pkg::IN_W-1:0]  point_c_y;

  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                point_c_x, point_c_y, output ready);
endinterface

interface circ_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [circ_pkg::OUT_W-1:0] centre_x;
  logic signed [circ_pkg::OUT_W-1:0] centre_y;
  logic [circ_pkg::OUT_W-1:0]        radius;
  logic                              collinear;
  logic                              saturated;

  modport source (output valid, centre_x, centre_y, radius, collinear, saturated,
                  input ready);
  modport sink (input valid, centre_x, centre_y, radius, collinear, saturated,
                output ready);
endinterface

/* rtl/circ_front.sv */
// Front pipeline: takes a request, forms differences, cross products and
// the scaled numerators, and classifies collinear triples. Depends on circ_pkg.
module circ_front #(
  parameter int CW = circ_pkg::COORD_BITS_DEF,
  parameter int FB = circ_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  circ_in_if.sink                                   req_i,
  input  circ_pkg::fifo_stat_t                      stat_i,
  output logic                                      push_o,
  output logic [circ_pkg::item_w(CW, FB)-1:0]       item_o
);
  import circ_pkg::*;

  localparam int DW   = diff_w(CW);
  localparam int PW   = prod_w(CW);
  localparam int B2W  = PW + 1;
  localparam int DENW = den_w(CW);
  localparam int MW   = num_w(CW, FB);
  localparam int NW   = MW - FB;
  localparam int TW   = NW - 2;

  typedef struct packed {
    logic                    coll;
    logic                    sgn_x;
    logic                    sgn_y;
    logic [DENW-1:0]         dm;
    logic [MW-1:0]           nmx;
    logic [MW-1:0]           nmy;
    logic signed [CW-1:0]    ax;
    logic signed [CW-1:0]    ay;
  } item_t;

  logic [4:0] vld_q;
  logic       en;

  logic signed [CW-1:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in;

  logic signed [CW-1:0] ax1_q, ay1_q;
  logic signed [DW-1:0] bx1_q, by1_q, cx1_q, cy1_q;

  logic signed [CW-1:0] ax2_q, ay2_q;
  logic signed [DW-1:0] bx2_q, by2_q, cx2_q, cy2_q;
  logic signed [PW-1:0] bxcy2_q, bycx2_q, bxx2_q, byy2_q, cxx2_q, cyy2_q;

  logic signed [CW-1:0]   ax3_q, ay3_q;
  logic signed [DW-1:0]   bx3_q, by3_q, cx3_q, cy3_q;
  logic signed [DENW-1:0] d3_q;
  logic signed [B2W-1:0]  b2_3_q, c2_3_q;

  logic signed [CW-1:0]   ax4_q, ay4_q;
  logic signed [DENW-1:0] d4_q;
  logic signed [TW-1:0]   axd4_q, cyb4_q, byc4_q, ayd4_q, bxc4_q, cxb4_q;

  logic signed [NW-1:0]   nx, ny;
  logic signed [MW-1:0]   nxs, nys;
  item_t                  item_d, item_q;

  assign en          = !(vld_q[4] && stat_i.full);
  assign push_o      = vld_q[4] && !stat_i.full;
  assign req_i.ready = en;
  assign item_o      = item_q;

  assign ax_in = req_i.point_a_x[CW-1:0];
  assign ay_in = req_i.point_a_y[CW-1:0];
  assign bx_in = req_i.point_b_x[CW-1:0];
  assign by_in = req_i.point_b_y[CW-1:0];
  assign cx_in = req_i.point_c_x[CW-1:0];
  assign cy_in = req_i.point_c_y[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q   <= ax_in;
      ay1_q   <= ay_in;
      bx1_q   <= DW'(bx_in) - DW'(ax_in);
      by1_q   <= DW'(by_in) - DW'(ay_in);
      cx1_q   <= DW'(cx_in) - DW'(ax_in);
      cy1_q   <= DW'(cy_in) - DW'(ay_in);

      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      bx2_q   <= bx1_q;
      by2_q   <= by1_q;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      bxcy2_q <= PW'(bx1_q) * PW'(cy1_q);
      bycx2_q <= PW'(by1_q) * PW'(cx1_q);
      bxx2_q  <= PW'(bx1_q) * PW'(bx1_q);
      byy2_q  <= PW'(by1_q) * PW'(by1_q);
      cxx2_q  <= PW'(cx1_q) * PW'(cx1_q);
      cyy2_q  <= PW'(cy1_q) * PW'(cy1_q);

      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      bx3_q   <= bx2_q;
      by3_q   <= by2_q;
      cx3_q   <= cx2_q;
      cy3_q   <= cy2_q;
      d3_q    <= (DENW'(bxcy2_q) - DENW'(bycx2_q)) <<< 1;
      b2_3_q  <= B2W'(bxx2_q) + B2W'(byy2_q);
      c2_3_q  <= B2W'(cxx2_q) + B2W'(cyy2_q);

      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      d4_q    <= d3_q;
      axd4_q  <= TW'(ax3_q) * TW'(d3_q);
      ayd4_q  <= TW'(ay3_q) * TW'(d3_q);
      cyb4_q  <= TW'(cy3_q) * TW'(b2_3_q);
      byc4_q  <= TW'(by3_q) * TW'(c2_3_q);
      bxc4_q  <= TW'(bx3_q) * TW'(c2_3_q);
      cxb4_q  <= TW'(cx3_q) * TW'(b2_3_q);

      item_q  <= item_d;
    end
  end

  always_comb begin
    nx           = NW'(axd4_q) + NW'(cyb4_q) - NW'(byc4_q);
    ny           = NW'(ayd4_q) + NW'(bxc4_q) - NW'(cxb4_q);
    nxs          = MW'(nx) <<< FB;
    nys          = MW'(ny) <<< FB;
    item_d.coll  = (d4_q == '0);
    item_d.sgn_x = nxs[MW-1] ^ d4_q[DENW-1];
    item_d.sgn_y = nys[MW-1] ^ d4_q[DENW-1];
    item_d.dm    = d4_q[DENW-1] ? DENW'(-d4_q) : DENW'(d4_q);
    item_d.nmx   = nxs[MW-1] ? MW'(-nxs) : MW'(nxs);
    item_d.nmy   = nys[MW-1] ? MW'(-nys) : MW'(nys);
    item_d.ax    = ax4_q;
    item_d.ay    = ay4_q;
  end

endmodule

/* rtl/circ_fifo.sv */
// Short request queue between the front and back pipelines.
// Depends on circ_pkg.
module circ_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = circ_pkg::FIFO_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [W-1:0]         data_i,
  input  logic                 pop_i,
  output logic [W-1:0]         data_o,
  output circ_pkg::fifo_stat_t stat_o
);
  import circ_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (AW + 1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/circ_back.sv */
// Back pipeline: radix-2 dividers, radius squaring, bitwise square root
// and the result register. Depends on circ_pkg.
module circ_back #(
  parameter int CW = circ_pkg::COORD_BITS_DEF,
  parameter int FB = circ_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [circ_pkg::item_w(CW, FB)-1:0] item_i,
  input  circ_pkg::fifo_stat_t                stat_i,
  output logic                                pop_o,
  circ_out_if.source                          res_o
);
  import circ_pkg::*;

  localparam int DENW = den_w(CW);
  localparam int MW   = num_w(CW, FB);
  localparam int EW   = ext_w(CW, FB);
  localparam int AW   = DENW + MW;
  localparam logic signed [EW-1:0] I32_MAX = EW'(32'sh7fff_ffff);
  localparam logic signed [EW-1:0] I32_MIN = EW'(32'sh8000_0000);

  typedef struct packed {
    logic                    coll;
    logic                    sgn_x;
    logic                    sgn_y;
    logic [DENW-1:0]         dm;
    logic [MW-1:0]           nmx;
    logic [MW-1:0]           nmy;
    logic signed [CW-1:0]    ax;
    logic signed [CW-1:0]    ay;
  } item_t;

  typedef struct packed {
    logic                    coll;
    logic                    sgn_x;
    logic                    sgn_y;
    logic [DENW-1:0]         dm;
    logic [AW-1:0]           acc_x;
    logic [AW-1:0]           acc_y;
    logic signed [CW-1:0]    ax;
    logic signed [CW-1:0]    ay;
  } div_t;

  typedef struct packed {
    logic        coll;
    logic        satc;
    logic        big;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] mx;
    logic [31:0] my;
  } p1_t;

  typedef struct packed {
    logic        coll;
    logic        satc;
    logic        big;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [63:0] sx;
    logic [63:0] sy;
  } p2_t;

  typedef struct packed {
    logic        coll;
    logic        satc;
    logic        rsat;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [63:0] s;
    logic [63:0] res;
  } sq_t;

  function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                             input logic [DENW-1:0] dm);
    logic [AW:0]   t;
    logic [DENW:0] hi;
    t  = {acc, 1'b0};
    hi = t[AW:MW];
    if (hi >= {1'b0, dm}) begin
      hi   = hi - {1'b0, dm};
      t[0] = 1'b1;
    end
    return {hi[DENW-1:0], t[MW-1:0]};
  endfunction

  function automatic sq_t sqrt_step(input sq_t x, input logic [63:0] bitv);
    sq_t         y;
    logic [63:0] trial;
    y     = x;
    trial = x.res + bitv;
    if (x.s >= trial) begin
      y.s   = x.s - trial;
      y.res = (x.res >> 1) + bitv;
    end else begin
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  item_t            it;
  logic             en;
  logic [MW:0]      dvld_q;
  div_t             div_q [MW+1];
  logic             p1v_q, p2v_q;
  p1_t              p1_d, p1_q;
  p2_t              p2_q;
  logic [SQRT_STEPS:0] sqv_q;
  sq_t              sq_d0;
  sq_t              sq_q [SQRT_STEPS+1];
  logic             vout_q;
  logic signed [EW-1:0] ux, uy, dx, dy, axs, ays;
  logic [EW-1:0]    mx, my;
  logic [64:0]      sum;

  assign it          = item_i;
  assign en          = !vout_q || res_o.ready;
  assign pop_o       = !stat_i.empty && en;
  assign res_o.valid = vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
      p1v_q  <= 1'b0;
      p2v_q  <= 1'b0;
      sqv_q  <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      dvld_q <= {dvld_q[MW-1:0], pop_o};
      p1v_q  <= dvld_q[MW];
      p2v_q  <= p1v_q;
      sqv_q  <= {sqv_q[SQRT_STEPS-1:0], p2v_q};
      vout_q <= sqv_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= '{coll: it.coll, sgn_x: it.sgn_x, sgn_y: it.sgn_y, dm: it.dm,
                    acc_x: AW'(it.nmx), acc_y: AW'(it.nmy), ax: it.ax, ay: it.ay};
      for (int k = 0; k < MW; k++) begin
        div_q[k+1] <= '{coll: div_q[k].coll, sgn_x: div_q[k].sgn_x,
                        sgn_y: div_q[k].sgn_y, dm: div_q[k].dm,
                        acc_x: div_step(div_q[k].acc_x, div_q[k].dm),
                        acc_y: div_step(div_q[k].acc_y, div_q[k].dm),
                        ax: div_q[k].ax, ay: div_q[k].ay};
      end
    end
  end

  always_comb begin
    ux   = div_q[MW].sgn_x ? -$signed(EW'(div_q[MW].acc_x[MW-1:0]))
                           :  $signed(EW'(div_q[MW].acc_x[MW-1:0]));
    uy   = div_q[MW].sgn_y ? -$signed(EW'(div_q[MW].acc_y[MW-1:0]))
                           :  $signed(EW'(div_q[MW].acc_y[MW-1:0]));
    axs  = EW'(div_q[MW].ax) <<< FB;
    ays  = EW'(div_q[MW].ay) <<< FB;
    dx   = axs - ux;
    dy   = ays - uy;
    mx   = dx[EW-1] ? EW'(-dx) : EW'(dx);
    my   = dy[EW-1] ? EW'(-dy) : EW'(dy);
    p1_d.coll = div_q[MW].coll;
    p1_d.big  = (|mx[EW-1:32]) || (|my[EW-1:32]);
    p1_d.mx   = mx[31:0];
    p1_d.my   = my[31:0];
    p1_d.satc = 1'b0;
    if (ux > I32_MAX) begin
      p1_d.cx   = 32'h7fff_ffff;
      p1_d.satc = 1'b1;
    end else if (ux < I32_MIN) begin
      p1_d.cx   = 32'h8000_0000;
      p1_d.satc = 1'b1;
    end else begin
      p1_d.cx = ux[31:0];
    end
    if (uy > I32_MAX) begin
      p1_d.cy   = 32'h7fff_ffff;
      p1_d.satc = 1'b1;
    end else if (uy < I32_MIN) begin
      p1_d.cy   = 32'h8000_0000;
      p1_d.satc = 1'b1;
    end else begin
      p1_d.cy = uy[31:0];
    end
  end

  always_comb begin
    sum        = 65'(p2_q.sx) + 65'(p2_q.sy);
    sq_d0.coll = p2_q.coll;
    sq_d0.satc = p2_q.satc;
    sq_d0.rsat = p2_q.big || sum[64];
    sq_d0.cx   = p2_q.cx;
    sq_d0.cy   = p2_q.cy;
    sq_d0.s    = sum[63:0];
    sq_d0.res  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q      <= p1_d;
      p2_q.coll <= p1_q.coll;
      p2_q.satc <= p1_q.satc;
      p2_q.big  <= p1_q.big;
      p2_q.cx   <= p1_q.cx;
      p2_q.cy   <= p1_q.cy;
      p2_q.sx   <= 64'(p1_q.mx) * 64'(p1_q.mx);
      p2_q.sy   <= 64'(p1_q.my) * 64'(p1_q.my);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= sq_d0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_q[k+1] <= sqrt_step(sq_q[k], 64'd1 << (2 * (SQRT_STEPS - 1 - k)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sq_q[SQRT_STEPS].coll) begin
        res_o.centre_x  <= '0;
        res_o.centre_y  <= '0;
        res_o.radius    <= '0;
        res_o.collinear <= 1'b1;
        res_o.saturated <= 1'b0;
      end else begin
        res_o.centre_x  <= sq_q[SQRT_STEPS].cx;
        res_o.centre_y  <= sq_q[SQRT_STEPS].cy;
        res_o.radius    <= sq_q[SQRT_STEPS].rsat ? 32'hffff_ffff
                                                 : sq_q[SQRT_STEPS].res[31:0];
        res_o.collinear <= 1'b0;
        res_o.saturated <= sq_q[SQRT_STEPS].satc || sq_q[SQRT_STEPS].rsat;
      end
    end
  end

endmodule

/* rtl/circumcircle_2d_centre_radius.sv */
// Top level of the circumcircle block: front pipeline, request queue, back pipeline.
// Depends on circ_pkg, circ_chan_if, circ_front, circ_fifo, circ_back.
//
//   channel | dir | handshake     | carries
//   req_i   | in  | valid / ready | three points, COORD_BITS-bit coordinates
//   res_o   | out | valid / ready | centre, radius, collinear, saturated
//
// One request a cycle sustained while res_o is ready; one result per request, in order.
// Latency is dominated by the radix-2 dividers and the 32-step square root pipeline.
// Reset clears only the valid bits and queue pointers; no clearing pass.
// A stalled result holds the back pipeline; the four-deep queue lets the front run on.
`include "circumcircle_2d_centre_radius_assert.svh"

module circumcircle_2d_centre_radius #(
  parameter int COORD_BITS = circ_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = circ_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  circ_in_if.sink    req_i,
  circ_out_if.source res_o
);
  import circ_pkg::*;

  localparam int IW = item_w(COORD_BITS, FRAC_BITS);

  logic          push, pop;
  logic [IW-1:0] item_in, item_out;
  fifo_stat_t    stat;

  circ_front #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (stat),
    .push_o (push),
    .item_o (item_in)
  );

  circ_fifo #(.W(IW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (item_in),
    .pop_i  (pop),
    .data_o (item_out),
    .stat_o (stat)
  );

  circ_back #(.CW(COORD_BITS), .FB(FRAC_BITS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_out),
    .stat_i (stat),
    .pop_o  (pop),
    .res_o  (res_o)
  );

  `CIRC_ASSERT_IMP(a_push_room, clk_i, rst_ni, push, !stat.full, "push into full queue")
  `CIRC_ASSERT_IMP(a_pop_data, clk_i, rst_ni, pop, !stat.empty, "pop from empty queue")
  `CIRC_ASSERT_NXT(a_push_fill, clk_i, rst_ni, push && !pop, !stat.empty, "queue lost a request")
  `CIRC_ASSERT_IMP(a_coll_zero, clk_i, rst_ni, res_o.valid && res_o.collinear, res_o.centre_x == 32'sd0 && res_o.centre_y == 32'sd0 && res_o.radius == 32'd0 && !res_o.saturated, "collinear result not cleared")

endmodule
